/* sv/vc_router_input_buffer_top_macros.svh */
// Assertion macros for the virtual channel router input buffer
`ifndef VC_ROUTER_INPUT_BUFFER_TOP_MACROS_SVH
`define VC_ROUTER_INPUT_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define VCIB_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vcib assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define VCIB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vcib assertion failed");

`endif

/* sv/vcib_pkg.sv */
// Shared types, sizes and codes of the virtual channel router input buffer
package vcib_pkg;

   // sizes
   localparam int NUM_VCS    = 4;
   localparam int MAX_DEPTH  = 16;
   localparam int DATA_WIDTH = 64;

   localparam int VC_IDX_W = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;
   localparam int PTR_W    = $clog2(MAX_DEPTH);
   localparam int CNT_W    = $clog2(MAX_DEPTH + 1);
   localparam int LEN_W    = 5;
   localparam int CMP_W    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int RAM_DEPTH = NUM_VCS * MAX_DEPTH;
   localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
   localparam int TAG_W     = 5;
   localparam int WORD_W    = TAG_W + DATA_WIDTH;

   localparam logic [LEN_W-1:0] BUFFER_LENGTH_RESET = LEN_W'(16);

   // input commands
   localparam logic [1:0] CMD_ARRIVE = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_GRANT  = 2'd2;

   // flit kinds
   localparam logic [1:0] KIND_HEAD    = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_TAIL    = 2'd2;

   // result kinds
   localparam logic [2:0] RES_FLIT_OUT   = 3'd0;
   localparam logic [2:0] RES_CREDIT     = 3'd1;
   localparam logic [2:0] RES_REQ_VC     = 3'd2;
   localparam logic [2:0] RES_REQ_SWITCH = 3'd3;
   localparam logic [2:0] RES_RELEASE_VC = 3'd4;
   localparam logic [2:0] RES_ERROR      = 3'd5;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_EMPTY    = 2'd2;
   localparam logic [1:0] ERR_PORT     = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [1:0]  chan;
      logic [1:0]  flit_kind;
      logic [2:0]  dest_port;
      logic [63:0] flit_data;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [1:0]  res_chan;
      logic [2:0]  res_port;
      logic [1:0]  res_flit_kind;
      logic [63:0] res_data;
      logic        credit_count;
      logic [1:0]  error_code;
      logic        last;
   } rsp_type;

endpackage

/* sv/vcib_flit_ram.sv */
// Simple dual-port flit memory with a registered read port
module vcib_flit_ram #(
   parameter int WIDTH  = 69,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/vc_router_input_buffer_top.sv */
// Top level of the virtual channel router input buffer
//
// Router input unit with one flit queue per virtual channel. Start an item
// by raising start while busy is low; the beat is taken on that clock edge
// and busy rises for the item's work. For flit arrivals, ticks, ignored
// items and failing grants, the acceptance cycle reads the front flit of
// the named channel from the synchronous flit memory and the next cycle
// decides, writes the memory and updates the queue pointers. A successful
// grant adds a credit state, since the forwarded flit and the returned
// credit leave as two beats on consecutive cycles. Results appear
// on rsp_item for exactly one cycle, marked by rsp_valid, starting the cycle
// after the deciding cycle; the receiver cannot stall them, so sample every
// beat on which rsp_valid is high. The next item may be started while the
// last result of the previous one is still on the result ports. Queue
// occupancy lives in per-channel fill counts, so no clearing pass follows
// reset. Write buffer_length through csr_valid / csr_data only while idle.
module vc_router_input_buffer_top (
   input  logic                    clock,
   input  logic                    reset,
   // command channel
   input  logic                    start,
   output logic                    busy,
   input  vcib_pkg::req_type       req_item,
   // result channel
   output logic                    rsp_valid,
   output vcib_pkg::rsp_type       rsp_item,
   // configuration channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [vcib_pkg::LEN_W-1:0] csr_data
);

   `include "vc_router_input_buffer_top_macros.svh"

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CREDIT
   } state_type;

   localparam logic [vcib_pkg::ADDR_W-1:0] DEPTH_A =
      vcib_pkg::ADDR_W'(vcib_pkg::MAX_DEPTH);
   localparam logic [vcib_pkg::PTR_W-1:0] PTR_LAST =
      vcib_pkg::PTR_W'(vcib_pkg::MAX_DEPTH - 1);

   state_type                           state_ff, state_in;
   vcib_pkg::req_type                   item_ff, item_in;
   logic [vcib_pkg::PTR_W-1:0]          rd_ptr_ff [vcib_pkg::NUM_VCS];
   logic [vcib_pkg::PTR_W-1:0]          rd_ptr_in [vcib_pkg::NUM_VCS];
   logic [vcib_pkg::PTR_W-1:0]          wr_ptr_ff [vcib_pkg::NUM_VCS];
   logic [vcib_pkg::PTR_W-1:0]          wr_ptr_in [vcib_pkg::NUM_VCS];
   logic [vcib_pkg::CNT_W-1:0]          fill_ff   [vcib_pkg::NUM_VCS];
   logic [vcib_pkg::CNT_W-1:0]          fill_in   [vcib_pkg::NUM_VCS];
   logic [1:0]                          cur_vc_ff, cur_vc_in;
   logic [2:0]                          cur_port_ff, cur_port_in;
   logic [vcib_pkg::LEN_W-1:0]          buffer_length_ff, buffer_length_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   vcib_pkg::rsp_type                   rsp_ff, rsp_in;

   // memory ports
   logic                                ram_we, ram_re;
   logic [vcib_pkg::ADDR_W-1:0]         ram_waddr, ram_raddr;
   logic [vcib_pkg::WORD_W-1:0]         ram_wdata, ram_rdata;

   // decoded item fields
   logic                                acc_ok, exe_ok;
   logic [vcib_pkg::VC_IDX_W-1:0]       acc_idx, exe_idx;
   logic [vcib_pkg::CNT_W-1:0]          exe_fill;
   logic [vcib_pkg::CMP_W-1:0]          limit;
   logic                                queue_full;
   logic [1:0]                          front_kind;
   logic [2:0]                          front_port;

   vcib_flit_ram #(
      .WIDTH  (vcib_pkg::WORD_W),
      .DEPTH  (vcib_pkg::RAM_DEPTH),
      .ADDR_W (vcib_pkg::ADDR_W)
   ) u_flit_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Qualify channels: an out-of-range channel indexes queue zero but does nothing.
   assign acc_ok  = ({3'b000, req_item.chan} < 5'(vcib_pkg::NUM_VCS));
   assign exe_ok  = ({3'b000, item_ff.chan} < 5'(vcib_pkg::NUM_VCS));
   assign acc_idx = acc_ok ? vcib_pkg::VC_IDX_W'(req_item.chan) : '0;
   assign exe_idx = exe_ok ? vcib_pkg::VC_IDX_W'(item_ff.chan) : '0;

   // Read the front flit of the named queue while the beat is taken.
   assign ram_raddr = vcib_pkg::ADDR_W'(acc_idx) * DEPTH_A
                    + vcib_pkg::ADDR_W'(rd_ptr_ff[acc_idx]);

   assign exe_fill   = fill_ff[exe_idx];
   assign front_kind = ram_rdata[vcib_pkg::DATA_WIDTH +: 2];
   assign front_port = ram_rdata[vcib_pkg::DATA_WIDTH + 2 +: 3];

   // Clamp buffer_length to the physical queue depth.
   assign limit = (vcib_pkg::CMP_W'(buffer_length_ff) > vcib_pkg::CMP_W'(vcib_pkg::MAX_DEPTH))
                ? vcib_pkg::CMP_W'(vcib_pkg::MAX_DEPTH)
                : vcib_pkg::CMP_W'(buffer_length_ff);
   assign queue_full = (vcib_pkg::CMP_W'(exe_fill) >= limit);

   always_comb begin
      state_in         = state_ff;
      item_in          = item_ff;
      rd_ptr_in        = rd_ptr_ff;
      wr_ptr_in        = wr_ptr_ff;
      fill_in          = fill_ff;
      cur_vc_in        = cur_vc_ff;
      cur_port_in      = cur_port_ff;
      buffer_length_in = buffer_length_ff;
      rsp_valid_in     = 1'b0;
      rsp_in           = '0;
      ram_we           = 1'b0;
      ram_re           = 1'b0;
      ram_waddr        = vcib_pkg::ADDR_W'(exe_idx) * DEPTH_A
                       + vcib_pkg::ADDR_W'(wr_ptr_ff[exe_idx]);
      ram_wdata        = {item_ff.dest_port, item_ff.flit_kind,
                          item_ff.flit_data[vcib_pkg::DATA_WIDTH-1:0]};

      // Take a register write only between items.
      if (csr_valid && csr_ready) begin
         buffer_length_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in  = req_item;
               ram_re   = 1'b1;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in        = ST_IDLE;
            rsp_in.res_chan = item_ff.chan;
            rsp_in.last     = 1'b1;
            if (exe_ok) begin
               case (item_ff.command)
                  vcib_pkg::CMD_ARRIVE: begin
                     if (queue_full) begin
                        // Drop the flit and report the overflow.
                        rsp_valid_in       = 1'b1;
                        rsp_in.result_kind = vcib_pkg::RES_ERROR;
                        rsp_in.error_code  = vcib_pkg::ERR_OVERFLOW;
                     end else begin
                        ram_we             = 1'b1;
                        wr_ptr_in[exe_idx] = (wr_ptr_ff[exe_idx] == PTR_LAST)
                                           ? '0 : wr_ptr_ff[exe_idx] + 1'b1;
                        fill_in[exe_idx]   = exe_fill + 1'b1;
                     end
                  end

                  vcib_pkg::CMD_TICK: begin
                     if (exe_fill != '0) begin
                        case (front_kind)
                           vcib_pkg::KIND_HEAD: begin
                              // Latch the current channel and ask for a VC.
                              cur_vc_in          = item_ff.chan;
                              cur_port_in        = front_port;
                              rsp_valid_in       = 1'b1;
                              rsp_in.result_kind = vcib_pkg::RES_REQ_VC;
                              rsp_in.res_chan    = item_ff.chan;
                              rsp_in.res_port    = front_port;
                           end
                           vcib_pkg::KIND_PAYLOAD: begin
                              rsp_valid_in       = 1'b1;
                              rsp_in.result_kind = vcib_pkg::RES_REQ_SWITCH;
                              rsp_in.res_chan    = cur_vc_ff;
                              rsp_in.res_port    = cur_port_ff;
                           end
                           vcib_pkg::KIND_TAIL: begin
                              rsp_valid_in       = 1'b1;
                              rsp_in.result_kind = vcib_pkg::RES_RELEASE_VC;
                              rsp_in.res_chan    = cur_vc_ff;
                              rsp_in.res_port    = cur_port_ff;
                           end
                           default: begin
                              // Unknown flit kind: leave it queued, say nothing.
                           end
                        endcase
                     end
                  end

                  vcib_pkg::CMD_GRANT: begin
                     rsp_valid_in = 1'b1;
                     if (exe_fill == '0) begin
                        rsp_in.result_kind = vcib_pkg::RES_ERROR;
                        rsp_in.error_code  = vcib_pkg::ERR_EMPTY;
                     end else if (front_port != item_ff.dest_port) begin
                        // Hold the flit; report the port it wants.
                        rsp_in.result_kind = vcib_pkg::RES_ERROR;
                        rsp_in.error_code  = vcib_pkg::ERR_PORT;
                        rsp_in.res_port    = front_port;
                     end else begin
                        // Pop and forward; the credit beat follows.
                        rd_ptr_in[exe_idx]   = (rd_ptr_ff[exe_idx] == PTR_LAST)
                                             ? '0 : rd_ptr_ff[exe_idx] + 1'b1;
                        fill_in[exe_idx]     = exe_fill - 1'b1;
                        rsp_in.result_kind   = vcib_pkg::RES_FLIT_OUT;
                        rsp_in.res_port      = front_port;
                        rsp_in.res_flit_kind = front_kind;
                        rsp_in.res_data      =
                           64'(ram_rdata[vcib_pkg::DATA_WIDTH-1:0]);
                        rsp_in.last          = 1'b0;
                        state_in             = ST_CREDIT;
                     end
                  end

                  default: begin
                     // Unknown command: drop the item.
                  end
               endcase
            end
         end

         ST_CREDIT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.result_kind  = vcib_pkg::RES_CREDIT;
            rsp_in.res_chan     = item_ff.chan;
            rsp_in.credit_count = 1'b1;
            rsp_in.last         = 1'b1;
            state_in            = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cur_vc_ff        <= '0;
         cur_port_ff      <= '0;
         buffer_length_ff <= vcib_pkg::BUFFER_LENGTH_RESET;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < vcib_pkg::NUM_VCS; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
            fill_ff[i]   <= '0;
         end
      end else begin
         state_ff         <= state_in;
         cur_vc_ff        <= cur_vc_in;
         cur_port_ff      <= cur_port_in;
         buffer_length_ff <= buffer_length_in;
         rsp_valid_ff     <= rsp_valid_in;
         rd_ptr_ff        <= rd_ptr_in;
         wr_ptr_ff        <= wr_ptr_in;
         fill_ff          <= fill_in;
      end
      // payload registers
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // An accepted beat always occupies the deciding cycle.
   `VCIB_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // A forwarded flit is always followed by its credit beat.
   `VCIB_ASSERT_NEXT(a_flit_then_credit,
      rsp_valid && rsp_item.result_kind == vcib_pkg::RES_FLIT_OUT,
      rsp_valid && rsp_item.result_kind == vcib_pkg::RES_CREDIT)
   // A credit beat only follows a forwarded flit.
   `VCIB_ASSERT_SAME(a_credit_after_flit,
      rsp_valid && rsp_item.result_kind == vcib_pkg::RES_CREDIT,
      $past(rsp_valid) && $past(rsp_item.result_kind) == vcib_pkg::RES_FLIT_OUT)
   // Only the forwarded flit is a non-final beat.
   `VCIB_ASSERT_SAME(a_last_marking,
      rsp_valid && !rsp_item.last,
      rsp_item.result_kind == vcib_pkg::RES_FLIT_OUT)
   // The queue of the channel in hand never holds more than its depth.
   `VCIB_ASSERT_SAME(a_fill_bound, 1'b1,
      vcib_pkg::CMP_W'(exe_fill) <= vcib_pkg::CMP_W'(vcib_pkg::MAX_DEPTH))

endmodule
